>>> src/multi_mode_crc_register_engine_defines.svh
// Assertion macros for the multi-mode CRC register engine.
`ifndef MULTI_MODE_CRC_REGISTER_ENGINE_DEFINES_SVH
`define MULTI_MODE_CRC_REGISTER_ENGINE_DEFINES_SVH

// same-cycle implication
`define MMCRC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmcrc assertion failed");

// next-cycle implication
`define MMCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmcrc assertion failed");

`endif

>>> src/mmcrc_pkg.sv
// Types and constants shared by the multi-mode CRC register engine.
package mmcrc_pkg;

  typedef enum logic [1:0] {
    ACT_CONTROL = 2'd0,
    ACT_SEED    = 2'd1,
    ACT_DATA    = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_CRC8 = 2'd1,
    MODE_8005 = 2'd2,
    MODE_1021 = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  msb_first;
  } crc_cfg_t;

  localparam int CTRL_MSB_BIT   = 2;
  localparam int CTRL_CLEAR_BIT = 7;

  localparam logic [7:0]  POLY8      = 8'h07;
  localparam logic [7:0]  POLY8_REV  = 8'hE0;
  localparam logic [15:0] POLY_8005  = 16'h8005;
  localparam logic [15:0] REV_8005   = 16'hA001;
  localparam logic [15:0] POLY_1021  = 16'h1021;
  localparam logic [15:0] REV_1021   = 16'h8408;

endpackage

>>> src/multi_mode_crc_register_engine.sv
// Top level of the multi-mode CRC register engine.
// One bus transaction is accepted per clock while in_stall is low; its result (the
// CRC register after the transaction) is presented from the output register. A full
// byte update (eight bit steps, unrolled in the byte unit) is combinational, so
// back-to-back unstalled transactions sustain one per clock. A skid register behind
// the output register keeps input acceptance going for one transaction while the
// output is stalled; in_stall rises only when that skid register is occupied.
`include "multi_mode_crc_register_engine_defines.svh"

module multi_mode_crc_register_engine
  import mmcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] crc_value
);

  logic [15:0] crc_reg;
  logic [15:0] crc_reg_next;
  crc_cfg_t    cfg;
  crc_cfg_t    cfg_next;
  logic [15:0] crc_upd;
  logic        skid_valid;
  logic [15:0] skid_crc;
  logic        accept;
  logic        out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  mmcrc_byte u_byte (
    .crc      (crc_reg),
    .cfg      (cfg),
    .data     (value[7:0]),
    .crc_next (crc_upd)
  );

  always_comb begin
    crc_reg_next = crc_reg;
    cfg_next     = cfg;
    unique case (action_t'(action))
      ACT_CONTROL: begin
        cfg_next.mode      = mode_t'(value[1:0]);
        cfg_next.msb_first = value[CTRL_MSB_BIT];
        if (value[CTRL_CLEAR_BIT]) begin
          crc_reg_next = '0;
        end
      end
      ACT_SEED: crc_reg_next = value;
      ACT_DATA: crc_reg_next = crc_upd;
      default:  crc_reg_next = crc_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg       <= '0;
      cfg.mode      <= MODE_OFF;
      cfg.msb_first <= 1'b0;
    end else if (accept) begin
      crc_reg <= crc_reg_next;
      cfg     <= cfg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        crc_value  <= skid_crc;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          crc_value <= crc_reg_next;
        end
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_crc   <= crc_reg_next;
    end
  end

  `MMCRC_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `MMCRC_ASSERT_NEXT(a_read_keeps_crc, clk, rst,
    accept && action == ACT_READ, crc_reg == $past(crc_reg))
  `MMCRC_ASSERT_NEXT(a_seed_loads, clk, rst,
    accept && action == ACT_SEED, crc_reg == $past(value))
  `MMCRC_ASSERT_NEXT(a_off_keeps_crc, clk, rst,
    accept && action == ACT_DATA && cfg.mode == MODE_OFF, crc_reg == $past(crc_reg))

endmodule

>>> src/mmcrc_byte.sv
// Bytewise CRC update: eight unrolled bit steps in each CRC mode and bit order.
module mmcrc_byte
  import mmcrc_pkg::*;
(
  input  logic [15:0] crc,
  input  crc_cfg_t    cfg,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);

  always_comb begin
    logic [7:0]  c8;
    logic [15:0] c16;
    logic [15:0] pn;
    logic [15:0] pr;
    c8  = crc[7:0] ^ data;
    c16 = '0;
    pn  = (cfg.mode == MODE_8005) ? POLY_8005 : POLY_1021;
    pr  = (cfg.mode == MODE_8005) ? REV_8005 : REV_1021;
    unique case (cfg.mode)
      MODE_CRC8: begin
        for (int i = 0; i < 8; i++) begin
          if (cfg.msb_first) begin
            c8 = c8[7] ? ({c8[6:0], 1'b0} ^ POLY8) : {c8[6:0], 1'b0};
          end else begin
            c8 = c8[0] ? ({1'b0, c8[7:1]} ^ POLY8_REV) : {1'b0, c8[7:1]};
          end
        end
        crc_next = {8'h00, c8};
      end
      MODE_8005, MODE_1021: begin
        if (cfg.msb_first) begin
          c16 = crc ^ {data, 8'h00};
        end else begin
          c16 = crc ^ {8'h00, data};
        end
        for (int i = 0; i < 8; i++) begin
          if (cfg.msb_first) begin
            c16 = c16[15] ? ({c16[14:0], 1'b0} ^ pn) : {c16[14:0], 1'b0};
          end else begin
            c16 = c16[0] ? ({1'b0, c16[15:1]} ^ pr) : {1'b0, c16[15:1]};
          end
        end
        crc_next = c16;
      end
      default: begin
        crc_next = crc;
      end
    endcase
  end

endmodule

>>> tb/multi_mode_crc_register_engine_tb.sv
// Self-checking testbench for the multi-mode CRC register engine.
`timescale 1ns / 1ps

module multi_mode_crc_register_engine_tb;
  import mmcrc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 150;
  localparam int DRAIN_WAIT  = 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  action_t     action;
  logic [15:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] crc_value;

  logic [15:0] crc_state;
  mode_t       mode_state;
  bit          msb_state;
  logic [15:0] crc_expect_q[$];

  int cycle_count;
  int fail_count;
  bit send_idling;
  bit recv_idling;
  bit long_hold_req;

  multi_mode_crc_register_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .crc_value (crc_value)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] crc_after_byte(logic [15:0] crc, mode_t mode, bit msb,
                                                 logic [7:0] d);
    logic [15:0] c;
    logic [15:0] pn;
    logic [15:0] pr;
    int i;
    c = crc;
    case (mode)
      MODE_CRC8: begin
        c = {8'h00, crc[7:0] ^ d};
        for (i = 0; i < 8; i++) begin
          if (msb) begin
            c = c[7] ? {8'h00, c[6:0] ^ POLY8[7:1], POLY8[0]} : {8'h00, c[6:0], 1'b0};
          end else begin
            c = c[0] ? ({1'b0, c[15:1]} ^ {8'h00, POLY8_REV}) : {1'b0, c[15:1]};
          end
        end
      end
      MODE_8005, MODE_1021: begin
        pn = (mode == MODE_8005) ? POLY_8005 : POLY_1021;
        pr = (mode == MODE_8005) ? REV_8005 : REV_1021;
        if (msb) begin
          c = crc ^ {d, 8'h00};
          for (i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ pn) : {c[14:0], 1'b0};
        end else begin
          c = crc ^ {8'h00, d};
          for (i = 0; i < 8; i++)
            c = c[0] ? ({1'b0, c[15:1]} ^ pr) : {1'b0, c[15:1]};
        end
      end
      default: c = crc;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] crc_after_access(action_t act, logic [15:0] val);
    case (act)
      ACT_CONTROL: begin
        mode_state = mode_t'(val[1:0]);
        msb_state  = val[CTRL_MSB_BIT];
        if (val[CTRL_CLEAR_BIT]) crc_state = 16'h0000;
      end
      ACT_SEED: crc_state = val;
      ACT_DATA: crc_state = crc_after_byte(crc_state, mode_state, msb_state, val[7:0]);
      default: ;
    endcase
    return crc_state;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_access(input action_t act, input logic [15:0] val);
    int gap;
    gap = send_idling ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    crc_expect_q.push_back(crc_after_access(act, val));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (crc_expect_q.size() == 0) begin
        $error("unexpected transaction: crc_value=%h", crc_value);
        fail_count++;
      end else begin
        if (crc_value !== crc_expect_q[0]) begin
          $error("crc_value mismatch: expected %h, actual %h", crc_expect_q[0], crc_value);
          fail_count++;
        end
        void'(crc_expect_q.pop_front());
      end
    end
  end

  initial begin : out_stall_gen
    int run;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (recv_idling && $urandom_range(0, 3) == 0) begin
        run = pick_gap();
        if (run == 0) run = 1;
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic run_reset();
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    crc_state  = 16'h0000;
    mode_state = MODE_OFF;
    msb_state  = 1'b0;
  endtask

  task automatic test_directed_cases();
    send_idling = 1'b1;
    recv_idling = 1'b1;
    send_access(ACT_READ,    16'h0000);
    send_access(ACT_SEED,    16'hFFFF);
    send_access(ACT_DATA,    16'h00A5);  // calculation off
    send_access(ACT_CONTROL, 16'h0001);
    send_access(ACT_DATA,    16'h0000);  // crc8 drops upper byte
    send_access(ACT_DATA,    16'hFFFF);
    send_access(ACT_CONTROL, 16'h0005);
    send_access(ACT_DATA,    16'hFF31);
    send_access(ACT_SEED,    16'hABCD);  // full seed kept in crc8 mode
    send_access(ACT_READ,    16'hFFFF);
    send_access(ACT_DATA,    16'h0000);
    send_access(ACT_CONTROL, 16'h0002);
    send_access(ACT_DATA,    16'h00FF);
    send_access(ACT_CONTROL, 16'h0006);
    send_access(ACT_DATA,    16'h0080);
    send_access(ACT_CONTROL, 16'h0003);
    send_access(ACT_SEED,    16'hFFFF);
    send_access(ACT_DATA,    16'h0031);
    send_access(ACT_CONTROL, 16'h0007);
    send_access(ACT_DATA,    16'h00FF);
    send_access(ACT_CONTROL, 16'hFF7F);  // unused bits set, no clear
    send_access(ACT_CONTROL, 16'h0084);  // clear with new mode
    send_access(ACT_DATA,    16'h0012);
    send_access(ACT_CONTROL, 16'h0080);
  endtask

  task automatic test_backpressure_fill();
    int i;
    send_idling   = 1'b0;
    recv_idling   = 1'b0;
    long_hold_req = 1'b1;
    send_access(ACT_CONTROL, 16'h0083);
    for (i = 0; i < 23; i++)
      send_access(ACT_DATA, 16'($urandom));
  endtask

  task automatic test_random_streams(input int n_items, input bit with_idling);
    int sent;
    int burst;
    int i;
    logic [15:0] ctrl;
    send_idling = with_idling;
    recv_idling = with_idling;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_access(action_t'($urandom_range(0, 3)), 16'($urandom));
        sent++;
      end else begin
        ctrl = 16'($urandom);
        send_access(ACT_CONTROL, ctrl);
        sent++;
        if ($urandom_range(0, 1) == 0) begin
          send_access(ACT_SEED, 16'($urandom));
          sent++;
        end
        burst = $urandom_range(1, 12);
        for (i = 0; i < burst; i++) begin
          if ($urandom_range(0, 7) == 0)
            send_access(ACT_READ, 16'($urandom));
          else
            send_access(ACT_DATA, 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_valid      = 1'b0;
    action        = ACT_READ;
    value         = 16'h0000;
    cycle_count   = 0;
    fail_count    = 0;
    send_idling   = 1'b0;
    recv_idling   = 1'b0;
    long_hold_req = 1'b0;
    run_reset();
    test_directed_cases();
    test_backpressure_fill();
    test_random_streams(600, 1'b1);
    test_random_streams(300, 1'b0);
    test_random_streams(500, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> multi_mode_crc_register_engine.f
+incdir+src
src/mmcrc_pkg.sv
src/mmcrc_byte.sv
src/multi_mode_crc_register_engine.sv
tb/multi_mode_crc_register_engine_tb.sv
